### hw/rtl/assert_macros.svh
// Assertion macros for the LRU cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop on every clk edge outside reset
`define LCX_ASSERT(lbl, prop, clk, rst_n) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lru cache check failed");

// Check prop on every clk edge, reset included
`define LCX_ASSERT_ALWAYS(lbl, prop, clk) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lru cache check failed");

`else

`define LCX_ASSERT(lbl, prop, clk, rst_n)
`define LCX_ASSERT_ALWAYS(lbl, prop, clk)

`endif

`endif

### hw/rtl/lcx_pkg.sv
// Shared types and codes for the LRU cache with expiry
`timescale 1ns / 1ps

package lcx_pkg;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_SET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_MISS    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_DONE    = 2'd3
  } status_e;

  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_MAX_AGE     = 1'b1;

  localparam int unsigned MAX_ENTRIES_W = 5;
  localparam int unsigned AGE_W         = 32;
  localparam int unsigned TIME_W        = 32;

  typedef struct packed {
    logic clear;
    logic fill;
    logic drop;
    logic load_rank;
    logic write_data;
    logic dec_en;
  } ent_ctl_t;

  typedef struct packed {
    status_e status;
    logic    evicted;
  } res_flags_t;

endpackage

### hw/rtl/lcx_entry.sv
// One cache line: key, value, timestamp, valid bit and recency rank
`timescale 1ns / 1ps

module lcx_entry #(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned RANK_W     = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcx_pkg::ent_ctl_t        ctl_i,
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [VALUE_BITS-1:0]    value_i,
  input  logic [lcx_pkg::TIME_W-1:0] stamp_i,
  input  logic [RANK_W-1:0]        new_rank_i,
  input  logic [RANK_W-1:0]        dec_thr_i,
  output logic                     valid_o,
  output logic                     match_o,
  output logic [RANK_W-1:0]        rank_o,
  output logic [VALUE_BITS-1:0]    value_o,
  output logic [lcx_pkg::TIME_W-1:0] stamp_o
);
  import lcx_pkg::*;

  logic                  valid_q, valid_d;
  logic [RANK_W-1:0]     rank_q, rank_d;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [TIME_W-1:0]     stamp_q;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    priority if (ctl_i.clear) begin
      valid_d = 1'b0;
      rank_d  = '0;
    end else if (ctl_i.fill) begin
      valid_d = 1'b1;
      rank_d  = new_rank_i;
    end else if (ctl_i.drop) begin
      valid_d = 1'b0;
      rank_d  = '0;
    end else if (ctl_i.load_rank) begin
      rank_d  = new_rank_i;
    end else if (ctl_i.dec_en && valid_q && (rank_q > dec_thr_i)) begin
      rank_d  = rank_q - RANK_W'(1);
    end else begin
      rank_d  = rank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fill) begin
      key_q <= key_i;
    end
    if (ctl_i.fill || ctl_i.write_data) begin
      value_q <= value_i;
      stamp_q <= stamp_i;
    end
  end

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == key_i);
  assign rank_o  = rank_q;
  assign value_o = value_q;
  assign stamp_o = stamp_q;

endmodule

### hw/rtl/lcx_ctrl.sv
// Operation decode: hit select, expiry test, eviction and line updates
`timescale 1ns / 1ps

module lcx_ctrl #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned RANK_W     = 4,
  parameter int unsigned CNT_W      = 5
) (
  input  logic                              fire_i,
  input  lcx_pkg::cmd_e                     cmd_i,
  input  logic [lcx_pkg::TIME_W-1:0]        now_i,
  input  logic [lcx_pkg::MAX_ENTRIES_W-1:0] max_entries_i,
  input  logic [lcx_pkg::AGE_W-1:0]         max_age_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic [CAPACITY-1:0]               valid_i,
  input  logic [CAPACITY-1:0]               match_i,
  input  logic [RANK_W-1:0]                 rank_i  [CAPACITY],
  input  logic [VALUE_BITS-1:0]             value_i [CAPACITY],
  input  logic [lcx_pkg::TIME_W-1:0]        stamp_i [CAPACITY],
  output lcx_pkg::ent_ctl_t                 ctl_o   [CAPACITY],
  output logic [RANK_W-1:0]                 new_rank_o,
  output logic [RANK_W-1:0]                 dec_thr_o,
  output logic [lcx_pkg::TIME_W-1:0]        stamp_wr_o,
  output logic [CNT_W-1:0]                  count_d_o,
  output logic [VALUE_BITS-1:0]             read_value_o,
  output lcx_pkg::res_flags_t               flags_o
);
  import lcx_pkg::*;

  logic                  hit_any;
  logic [RANK_W-1:0]     hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [TIME_W-1:0]     hit_stamp;
  logic [TIME_W-1:0]     age;
  logic                  expired;
  logic [CNT_W-1:0]      limit;
  logic                  full;
  logic [CAPACITY-1:0]   victim_oh;
  logic [CAPACITY-1:0]   free_vec;
  logic [CAPACITY-1:0]   fill_oh;
  logic                  evict;
  logic [CAPACITY-1:0]   drop_v, load_v, wr_v, fill_v;
  logic                  dec_all, clr_all;

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    hit_stamp = '0;
    victim_oh = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_rank     = hit_rank  | (match_i[i] ? rank_i[i]  : '0);
      hit_value    = hit_value | (match_i[i] ? value_i[i] : '0);
      hit_stamp    = hit_stamp | (match_i[i] ? stamp_i[i] : '0);
      victim_oh[i] = valid_i[i] && (rank_i[i] == '0);
    end
  end

  assign hit_any = |match_i;
  assign age     = now_i - hit_stamp;
  assign expired = (max_age_i != '0) && (AGE_W'(age) > max_age_i);

  always_comb begin
    if ((max_entries_i == '0) || (32'(max_entries_i) > 32'(CAPACITY))) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(max_entries_i);
    end
  end

  assign full       = count_i >= limit;
  assign evict      = (cmd_i == CMD_SET) && !hit_any && full;
  assign free_vec   = ~valid_i | (evict ? victim_oh : '0);
  assign fill_oh    = free_vec & (~free_vec + CAPACITY'(1));
  assign stamp_wr_o = (max_age_i == '0) ? '0 : now_i;

  always_comb begin
    drop_v       = '0;
    load_v       = '0;
    wr_v         = '0;
    fill_v       = '0;
    dec_all      = 1'b0;
    clr_all      = 1'b0;
    dec_thr_o    = hit_rank;
    new_rank_o   = RANK_W'(count_i - CNT_W'(1));
    count_d_o    = count_i;
    read_value_o = '0;
    flags_o      = '{status: ST_DONE, evicted: 1'b0};
    unique case (cmd_i)
      CMD_GET: begin
        if (!hit_any) begin
          flags_o.status = ST_MISS;
        end else if (expired) begin
          flags_o.status = ST_EXPIRED;
          drop_v         = match_i;
          dec_all        = 1'b1;
          count_d_o      = count_i - CNT_W'(1);
        end else begin
          flags_o.status = ST_HIT;
          read_value_o   = hit_value;
          load_v         = match_i;
          dec_all        = 1'b1;
        end
      end
      CMD_SET: begin
        if (hit_any) begin
          wr_v    = match_i;
          load_v  = match_i;
          dec_all = 1'b1;
        end else begin
          flags_o.evicted = evict;
          if (evict) begin
            drop_v    = victim_oh;
            dec_all   = 1'b1;
            dec_thr_o = '0;
          end
          fill_v     = fill_oh;
          new_rank_o = RANK_W'(count_i - CNT_W'(evict));
          count_d_o  = count_i - CNT_W'(evict) + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit_any) begin
          drop_v    = match_i;
          dec_all   = 1'b1;
          count_d_o = count_i - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        clr_all   = 1'b1;
        count_d_o = '0;
      end
      default: begin
        flags_o.status = ST_DONE;
      end
    endcase
    if (!fire_i) begin
      drop_v    = '0;
      load_v    = '0;
      wr_v      = '0;
      fill_v    = '0;
      dec_all   = 1'b0;
      clr_all   = 1'b0;
      count_d_o = count_i;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl_o[i] = '{clear:      clr_all,
                   fill:       fill_v[i],
                   drop:       drop_v[i],
                   load_rank:  load_v[i],
                   write_data: wr_v[i],
                   dec_en:     dec_all};
    end
  end

endmodule

### hw/rtl/lru_cache_with_expiry.sv
// Throughput: one word per cycle while the receiver does not stall the result
// register; the full-table key match and rank update run in a single pass
// between the input register and the result register.
// Reset clears all valid bits, recency ranks, the entry count and both
// configuration registers at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_cache_with_expiry #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [lcx_pkg::AGE_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [KEY_BITS-1:0]           lookup_key_i,
  input  logic [VALUE_BITS-1:0]         write_value_i,
  input  logic [lcx_pkg::TIME_W-1:0]    now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [VALUE_BITS-1:0]         read_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o,
  output logic                          evicted_o
);
  import lcx_pkg::*;

  localparam int unsigned RANK_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  logic [MAX_ENTRIES_W-1:0] max_entries_q;
  logic [AGE_W-1:0]         max_age_q;

  logic                  s1_valid_q, s1_valid_d;
  cmd_e                  s1_cmd_q;
  logic [KEY_BITS-1:0]   s1_key_q;
  logic [VALUE_BITS-1:0] s1_value_q;
  logic [TIME_W-1:0]     s1_now_q;

  logic                  out_valid_q, out_valid_d;
  res_flags_t            res_flags_q;
  logic [VALUE_BITS-1:0] res_value_q;
  logic [CNT_W-1:0]      count_q, count_d;

  logic accept_in, fire;

  logic [CAPACITY-1:0]   entry_valid, entry_match;
  logic [RANK_W-1:0]     entry_rank  [CAPACITY];
  logic [VALUE_BITS-1:0] entry_value [CAPACITY];
  logic [TIME_W-1:0]     entry_stamp [CAPACITY];
  ent_ctl_t              entry_ctl   [CAPACITY];

  logic [RANK_W-1:0]     new_rank, dec_thr;
  logic [TIME_W-1:0]     stamp_wr;
  logic [VALUE_BITS-1:0] res_value_d;
  res_flags_t            res_flags_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= '0;
      max_age_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_ENTRIES: max_entries_q <= cfg_data_i[MAX_ENTRIES_W-1:0];
        REG_MAX_AGE:     max_age_q     <= cfg_data_i;
        default:         max_age_q     <= max_age_q;
      endcase
    end
  end

  // Advance the held word when the result register is free or draining
  assign fire        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !fire;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = accept_in || (s1_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_cmd_q   <= cmd_e'(cmd_i);
      s1_key_q   <= lookup_key_i;
      s1_value_q <= write_value_i;
      s1_now_q   <= now_ms_i;
    end
    if (fire) begin
      res_flags_q <= res_flags_d;
      res_value_q <= res_value_d;
    end
  end

  logic [CNT_W-1:0] res_count_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_count_q <= count_d;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_line
    lcx_entry #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_W     (RANK_W)
    ) u_entry (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (entry_ctl[g]),
      .key_i      (s1_key_q),
      .value_i    (s1_value_q),
      .stamp_i    (stamp_wr),
      .new_rank_i (new_rank),
      .dec_thr_i  (dec_thr),
      .valid_o    (entry_valid[g]),
      .match_o    (entry_match[g]),
      .rank_o     (entry_rank[g]),
      .value_o    (entry_value[g]),
      .stamp_o    (entry_stamp[g])
    );
  end

  lcx_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .RANK_W     (RANK_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .fire_i        (fire),
    .cmd_i         (s1_cmd_q),
    .now_i         (s1_now_q),
    .max_entries_i (max_entries_q),
    .max_age_i     (max_age_q),
    .count_i       (count_q),
    .valid_i       (entry_valid),
    .match_i       (entry_match),
    .rank_i        (entry_rank),
    .value_i       (entry_value),
    .stamp_i       (entry_stamp),
    .ctl_o         (entry_ctl),
    .new_rank_o    (new_rank),
    .dec_thr_o     (dec_thr),
    .stamp_wr_o    (stamp_wr),
    .count_d_o     (count_d),
    .read_value_o  (res_value_d),
    .flags_o       (res_flags_d)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_flags_q.status;
  assign evicted_o     = res_flags_q.evicted;
  assign read_value_o  = res_value_q;
  assign entry_count_o = res_count_q;

  `LCX_ASSERT(a_count_tracks_valid, ($countones(entry_valid) == count_q), clk_i, rst_ni)
  `LCX_ASSERT(a_single_match, ($onehot0(entry_match)), clk_i, rst_ni)
  `LCX_ASSERT(a_fire_gives_result, (fire |=> out_valid_o), clk_i, rst_ni)
  `LCX_ASSERT(a_evict_keeps_count, (fire && res_flags_d.evicted |-> count_d == count_q), clk_i, rst_ni)

endmodule

### verif/cache_reply_checker.sv
// Checker for the LRU cache: mirrors the store, predicts every reply word and compares it
`timescale 1ns / 1ps

module cache_reply_checker #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic                          cfg_index_i,
  input  logic [lcx_pkg::AGE_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    cmd_i,
  input  logic [KEY_BITS-1:0]           lookup_key_i,
  input  logic [VALUE_BITS-1:0]         write_value_i,
  input  logic [lcx_pkg::TIME_W-1:0]    now_ms_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    status_i,
  input  logic [VALUE_BITS-1:0]         read_value_i,
  input  logic [$clog2(CAPACITY+1)-1:0] entry_count_i,
  input  logic                          evicted_i,
  output int                            fail_count_o,
  output int                            replies_waiting_o
);
  import lcx_pkg::*;

  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

  typedef struct packed {
    status_e               status;
    logic [VALUE_BITS-1:0] read_value;
    logic [COUNT_W-1:0]    count;
    logic                  evicted;
  } cache_reply_t;

  logic                     slot_used  [CAPACITY];
  logic [KEY_BITS-1:0]      slot_key   [CAPACITY];
  logic [VALUE_BITS-1:0]    slot_data  [CAPACITY];
  logic [TIME_W-1:0]        slot_stamp [CAPACITY];
  int unsigned              slot_rank  [CAPACITY];
  int unsigned              used_count;
  logic [MAX_ENTRIES_W-1:0] entry_limit;
  logic [AGE_W-1:0]         age_limit;
  cache_reply_t             replies_due [$];
  int                       errors;

  task automatic release_slot(input int s);
    for (int i = 0; i < CAPACITY; i++)
      if (slot_used[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
    slot_used[s] = 1'b0;
    slot_rank[s] = 0;
    used_count--;
  endtask

  task automatic promote_slot(input int s);
    for (int i = 0; i < CAPACITY; i++)
      if (slot_used[i] && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
    slot_rank[s] = used_count - 1;
  endtask

  task automatic predict_reply(input cmd_e c, input logic [KEY_BITS-1:0] key,
                               input logic [VALUE_BITS-1:0] data,
                               input logic [TIME_W-1:0] now, output cache_reply_t r);
    int               hit;
    int               free_slot;
    int unsigned      cap;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] age;
    hit = -1;
    r.status = ST_DONE;
    r.read_value = '0;
    r.evicted = 1'b0;
    for (int i = 0; i < CAPACITY; i++)
      if (slot_used[i] && slot_key[i] == key) hit = i;
    case (c)
      CMD_GET: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          age = now - slot_stamp[hit];
          if (age_limit != '0 && age > age_limit) begin
            release_slot(hit);
            r.status = ST_EXPIRED;
          end else begin
            promote_slot(hit);
            r.read_value = slot_data[hit];
            r.status = ST_HIT;
          end
        end
      end
      CMD_SET: begin
        stamp = (age_limit == '0) ? '0 : now;
        if (hit >= 0) begin
          slot_data[hit] = data;
          slot_stamp[hit] = stamp;
          promote_slot(hit);
        end else begin
          cap = (entry_limit == '0 || entry_limit > CAPACITY) ? CAPACITY : entry_limit;
          if (used_count >= cap) begin
            for (int i = 0; i < CAPACITY; i++)
              if (!r.evicted && slot_used[i] && slot_rank[i] == 0) begin
                release_slot(i);
                r.evicted = 1'b1;
              end
          end
          free_slot = -1;
          for (int i = CAPACITY - 1; i >= 0; i--)
            if (!slot_used[i]) free_slot = i;
          if (free_slot >= 0) begin
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_data[free_slot] = data;
            slot_stamp[free_slot] = stamp;
            slot_rank[free_slot] = used_count;
            used_count++;
          end
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) release_slot(hit);
      end
      default: begin
        for (int i = 0; i < CAPACITY; i++) begin
          slot_used[i] = 1'b0;
          slot_rank[i] = 0;
        end
        used_count = 0;
      end
    endcase
    r.count = COUNT_W'(used_count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
      end
      used_count = 0;
      entry_limit = '0;
      age_limit = '0;
      replies_due.delete();
      errors = 0;
      fail_count_o <= 0;
      replies_waiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MAX_ENTRIES) entry_limit = cfg_data_i[MAX_ENTRIES_W-1:0];
        else age_limit = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply word with nothing expected (status %0d)", $time, status_i);
          errors++;
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            errors++;
          end
          if (read_value_i !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     read_value_i);
            errors++;
          end
          if (entry_count_i !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                     entry_count_i);
            errors++;
          end
          if (evicted_i !== want.evicted) begin
            $display("%0t: evicted expected %0d actual %0d", $time, want.evicted, evicted_i);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_reply(cmd_e'(cmd_i), lookup_key_i, write_value_i, now_ms_i, want);
        replies_due.push_back(want);
      end
      fail_count_o <= errors;
      replies_waiting_o <= replies_due.size();
    end
  end

endmodule

### verif/testbench.sv
// Testbench top for the LRU cache: clock, reset, stimulus, receiver stalls and the verdict
`timescale 1ns / 1ps

module testbench;
  import lcx_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_WORDS  = 60;
  localparam int POOL_SIZE    = 24;
  localparam int HOLD_CYCLES  = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic [1:0]  cmd_i = '0;
  logic [63:0] lookup_key_i = '0;
  logic [31:0] write_value_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_stall_i = 1'b0;

  wire         cfg_ready_o;
  wire         in_stall_o;
  wire         out_valid_o;
  wire [1:0]   status_o;
  wire [31:0]  read_value_o;
  wire [4:0]   entry_count_o;
  wire         evicted_o;

  int          fail_count;
  int          replies_waiting;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          stall_mode_left = 0;
  logic [63:0] key_pool [POOL_SIZE];
  logic [31:0] clock_ms;

  lru_cache_with_expiry i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .evicted_o     (evicted_o)
  );

  cache_reply_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .cmd_i             (cmd_i),
    .lookup_key_i      (lookup_key_i),
    .write_value_i     (write_value_i),
    .now_ms_i          (now_ms_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_i          (status_o),
    .read_value_i      (read_value_o),
    .entry_count_i     (entry_count_o),
    .evicted_i         (evicted_o),
    .fail_count_o      (fail_count),
    .replies_waiting_o (replies_waiting)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      out_stall_i <= 1'b1;
      hold_ack <= hold_ack + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(5, 60);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= $urandom_range(0, 1);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic put_word(input cmd_e c, input logic [63:0] k, input logic [31:0] v,
                          input logic [31:0] now);
    if (burst_left == 0) begin
      if (in_valid_i) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    cmd_i <= c;
    lookup_key_i <= k;
    write_value_i <= v;
    now_ms_i <= now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (replies_waiting != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic reconfigure(input logic [31:0] entries, input logic [31:0] age);
    drain();
    write_reg(REG_MAX_ENTRIES, entries);
    write_reg(REG_MAX_AGE, age);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_word(input int pool_n, input int unsigned step_max);
    int          pick;
    cmd_e        c;
    logic [63:0] k;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 42) c = CMD_GET;
    else if (pick < 82) c = CMD_SET;
    else if (pick < 96) c = CMD_REMOVE;
    else c = CMD_CLEAR;
    k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, pool_n - 1)];
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 39) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, step_max);
    put_word(c, k, v, clock_ms);
  endtask

  initial begin
    logic [63:0] k1, k2, k3, k4;
    int unsigned ents, age, step;
    int          pool_n;
    k1 = 64'h0123_4567_89AB_CDEF;
    k2 = 64'hFEDC_BA98_7654_3210;
    k3 = 64'h8000_0000_0000_0001;
    k4 = 64'h5555_AAAA_3333_CCCC;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    clock_ms = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reconfigure(2, 10);
    put_word(CMD_GET, '0, '0, 100);
    put_word(CMD_SET, '0, '1, 100);
    put_word(CMD_SET, '1, '0, 100);
    put_word(CMD_GET, '0, '0, 110);
    put_word(CMD_SET, k1, 32'h1234_5678, 111);
    put_word(CMD_GET, '1, '0, 111);
    put_word(CMD_GET, '0, '0, 121);
    put_word(CMD_REMOVE, '0, '0, 121);
    put_word(CMD_REMOVE, k1, '0, 122);
    put_word(CMD_SET, k1, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
    put_word(CMD_GET, k1, '0, 5);
    put_word(CMD_GET, k1, '0, 10);
    put_word(CMD_SET, k2, 32'd1, 20);
    put_word(CMD_SET, k2, 32'd2, 25);
    put_word(CMD_GET, k2, '0, 34);
    put_word(CMD_CLEAR, k2, '1, 40);
    put_word(CMD_GET, k2, '0, 41);
    reconfigure(16, 0);
    put_word(CMD_SET, k1, 32'd7, 32'h8000_0000);
    put_word(CMD_SET, k2, 32'd8, 32'h8000_0001);
    put_word(CMD_SET, k3, 32'd9, 32'h8000_0002);
    put_word(CMD_SET, '0, 32'd10, 32'h8000_0003);
    reconfigure(2, 100);
    put_word(CMD_GET, k1, '0, 50);
    put_word(CMD_GET, k2, '0, 200);
    put_word(CMD_SET, k4, 32'hDEAD_BEEF, 200);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin ents = 0;  age = 0;                 step = 5;    pool_n = 20; end
        1: begin ents = 16; age = 1000;              step = 50;   pool_n = 24; end
        2: begin ents = 1;  age = 32'hFFFF_FFFF;     step = 100;  pool_n = 6;  end
        3: begin ents = 3;  age = 5;                 step = 3;    pool_n = 5;  end
        4: begin ents = 8;  age = 0;                 step = 10;   pool_n = 24; end
        5: begin ents = 0;  age = $urandom_range(20, 200); step = 20; pool_n = 16; end
        6: begin ents = 2;  age = 1;                 step = 1;    pool_n = 4;  end
        default: begin ents = $urandom_range(0, 16); age = $urandom; step = 1000;
                       pool_n = 12; end
      endcase
      reconfigure(ents, age);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ((ph == 4 || ph == 6) && n == 20) begin
          hold_req <= hold_req + 1;
          burst_left = 40;
        end
        random_word(pool_n, step);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && replies_waiting == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
